>>> rtl/prtc_pkg.sv
`timescale 1ns / 1ps
package prtc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [26:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divisor_zero;
  } out_t;

  typedef enum logic [1:0] {
    CfgTempTrim  = 2'd0,
    CfgPressA    = 2'd1,
    CfgPressB    = 2'd2,
    CfgPressC    = 2'd3
  } cfg_idx_e;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic signed [26:0] centi;
    logic               zero;
    logic               neg;
  } div_side_t;

  localparam int unsigned DivW = 64;
  localparam int unsigned RemW = 32;

  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] PressBase  = 64'd1048576;
  localparam logic [63:0] DivScale   = 64'd3125;

endpackage

>>> rtl/pressure_temperature_compensation_top.sv
`timescale 1ns / 1ps
// Barometric trim compensation engine.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one pair of
// 20-bit raw temperature and pressure readings per transaction. Output
// channel (out_valid_o / out_ready_i / out_data_o) returns temperature in
// 0.01 degC, pressure in Pa as Q24.8 and a flag for a zero divisor.
// Trim words are to be written through cfg_we_i / cfg_idx_i / cfg_data_i only
// while no transaction is in flight (the block does not enforce this); a write takes effect at once.
// The pipeline takes one transaction per cycle while the output buffer is not
// full; its depth is set by the 64 one-bit stages of the unsigned magnitude
// divider plus 16 stages of capture, arithmetic and split multiplies.
// Reset clears all trim registers to zero and empties the pipeline.
// When the receiver stalls, a two-entry output buffer absorbs the result
// in flight; once both entries are full in_ready_o drops and the whole
// pipeline holds until the output drains. Nothing is lost or repeated.
module pressure_temperature_compensation_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  prtc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output prtc_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [63:0]     cfg_data_i
);

  // configuration
  logic [47:0] temp_trim_q;
  logic [63:0] press_a_q;
  logic [63:0] press_b_q;
  logic [15:0] press_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0;
      press_a_q   <= '0;
      press_b_q   <= '0;
      press_c_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (prtc_pkg::cfg_idx_e'(cfg_idx_i))
        prtc_pkg::CfgTempTrim: temp_trim_q <= cfg_data_i[47:0];
        prtc_pkg::CfgPressA:   press_a_q   <= cfg_data_i;
        prtc_pkg::CfgPressB:   press_b_q   <= cfg_data_i;
        prtc_pkg::CfgPressC:   press_c_q   <= cfg_data_i[15:0];
        default:               temp_trim_q <= temp_trim_q;
      endcase
    end
  end

  logic [15:0]        t1_u, p1_u;
  logic signed [15:0] t2_s, t3_s, p2_s, p3_s, p4_s, p5_s, p6_s, p7_s, p8_s, p9_s;

  assign t1_u = temp_trim_q[15:0];
  assign t2_s = $signed(temp_trim_q[31:16]);
  assign t3_s = $signed(temp_trim_q[47:32]);
  assign p1_u = press_a_q[15:0];
  assign p2_s = $signed(press_a_q[31:16]);
  assign p3_s = $signed(press_a_q[47:32]);
  assign p4_s = $signed(press_a_q[63:48]);
  assign p5_s = $signed(press_b_q[15:0]);
  assign p6_s = $signed(press_b_q[31:16]);
  assign p7_s = $signed(press_b_q[47:32]);
  assign p8_s = $signed(press_b_q[63:48]);
  assign p9_s = $signed(press_c_q);

  // pipeline advance: hold everything while the output buffer is full
  logic skid_valid_q;
  logic en;
  assign en         = ~skid_valid_q;
  assign in_ready_o = en;

  logic [10:0] sv_q;
  logic [4:0]  pv_q;

  // stage 0: capture
  logic [19:0] s0_raw_t_q, s0_raw_p_q;
  // stage 1
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] s1_vt_d, s1_vt_q, s1_sq_d, s1_sq_q;
  logic [19:0]        s1_raw_p_q;
  // stage 2
  logic signed [22:0] s2_v1_d, s2_v1_q;
  logic signed [37:0] s2_m_d, s2_m_q;
  logic [19:0]        s2_raw_p_q;
  // stage 3
  logic signed [24:0] s3_fine_d, s3_fine_q;
  logic [19:0]        s3_raw_p_q;
  // stage 4
  logic signed [28:0] f5r;
  logic signed [26:0] s4_centi_d, s4_centi_q, s4_a_d, s4_a_q;
  logic [19:0]        s4_raw_p_q;
  // stage 5
  logic signed [53:0] s5_aa_d, s5_aa_q;
  logic signed [42:0] s5_ap5_d, s5_ap5_q, s5_ap2_d, s5_ap2_q;
  logic signed [26:0] s5_centi_q;
  logic [19:0]        s5_raw_p_q;
  // stage 6
  logic signed [69:0] b6_full, a3_full;
  logic [63:0]        s6_b6_q, s6_a3_q;
  logic signed [42:0] s6_ap5_q, s6_ap2_q;
  logic signed [26:0] s6_centi_q;
  logic [19:0]        s6_raw_p_q;
  // stage 7
  logic [63:0]        s7_b_d, s7_b_q, s7_av_d, s7_av_q;
  logic signed [26:0] s7_centi_q;
  logic [19:0]        s7_raw_p_q;
  // stage 8
  logic [79:0]        m1_full;
  logic [20:0]        pp;
  logic [63:0]        s8_m1_q, s8_num0_d, s8_num0_q;
  logic signed [26:0] s8_centi_q;
  // stage 9
  logic [75:0]        num_full;
  logic [63:0]        s9_num_q;
  logic [30:0]        s9_den_q;
  logic               s9_zero_q;
  logic signed [26:0] s9_centi_q;
  // stage 10: magnitudes for the divider
  logic [31:0]        den32;
  logic [63:0]        s10_ma_q;
  logic [31:0]        s10_mb_q;
  prtc_pkg::div_side_t s10_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[9:0], in_valid_i};
    end
  end

  assign d1 = $signed({1'b0, s0_raw_t_q[19:3]}) - $signed({1'b0, t1_u, 1'b0});
  assign d2 = $signed({1'b0, s0_raw_t_q[19:4]}) - $signed({1'b0, t1_u});
  assign s1_vt_d = d1 * t2_s;
  assign s1_sq_d = d2 * d2;

  assign s2_v1_d = $signed(s1_vt_q[33:11]);
  assign s2_m_d  = $signed(s1_sq_q[33:12]) * t3_s;

  assign s3_fine_d = s2_v1_q + $signed(s2_m_q[37:14]);

  assign f5r        = (29'(s3_fine_q) * 29'sd5) + 29'sd128;
  assign s4_centi_d = 27'($signed(f5r[28:8]));
  assign s4_a_d     = 27'(s3_fine_q) - $signed(27'(prtc_pkg::FineOffset));

  assign s5_aa_d  = s4_a_q * s4_a_q;
  assign s5_ap5_d = s4_a_q * p5_s;
  assign s5_ap2_d = s4_a_q * p2_s;

  assign b6_full = s5_aa_q * p6_s;
  assign a3_full = s5_aa_q * p3_s;

  assign s7_b_d  = s6_b6_q + (64'(s6_ap5_q) << 17) + (64'(p4_s) << 35);
  assign s7_av_d = 64'($signed(s6_a3_q) >>> 8) + (64'(s6_ap2_q) << 12) + (64'd1 << 47);

  assign m1_full   = s7_av_q * p1_u;
  assign pp        = 21'(prtc_pkg::PressBase) - {1'b0, s7_raw_p_q};
  assign s8_num0_d = {12'd0, pp, 31'd0} - s7_b_q;

  assign num_full = s8_num0_q * 12'(prtc_pkg::DivScale);

  assign den32 = {s9_den_q[30], s9_den_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_raw_t_q <= in_data_i.raw_temperature;
      s0_raw_p_q <= in_data_i.raw_pressure;

      s1_vt_q    <= s1_vt_d;
      s1_sq_q    <= s1_sq_d;
      s1_raw_p_q <= s0_raw_p_q;

      s2_v1_q    <= s2_v1_d;
      s2_m_q     <= s2_m_d;
      s2_raw_p_q <= s1_raw_p_q;

      s3_fine_q  <= s3_fine_d;
      s3_raw_p_q <= s2_raw_p_q;

      s4_centi_q <= s4_centi_d;
      s4_a_q     <= s4_a_d;
      s4_raw_p_q <= s3_raw_p_q;

      s5_aa_q    <= s5_aa_d;
      s5_ap5_q   <= s5_ap5_d;
      s5_ap2_q   <= s5_ap2_d;
      s5_centi_q <= s4_centi_q;
      s5_raw_p_q <= s4_raw_p_q;

      s6_b6_q    <= b6_full[63:0];
      s6_a3_q    <= a3_full[63:0];
      s6_ap5_q   <= s5_ap5_q;
      s6_ap2_q   <= s5_ap2_q;
      s6_centi_q <= s5_centi_q;
      s6_raw_p_q <= s5_raw_p_q;

      s7_b_q     <= s7_b_d;
      s7_av_q    <= s7_av_d;
      s7_centi_q <= s6_centi_q;
      s7_raw_p_q <= s6_raw_p_q;

      s8_m1_q    <= m1_full[63:0];
      s8_num0_q  <= s8_num0_d;
      s8_centi_q <= s7_centi_q;

      s9_num_q   <= num_full[63:0];
      s9_den_q   <= s8_m1_q[63:33];
      s9_zero_q  <= (s8_m1_q[63:33] == 31'd0);
      s9_centi_q <= s8_centi_q;

      s10_ma_q         <= s9_num_q[63] ? (64'd0 - s9_num_q) : s9_num_q;
      s10_mb_q         <= s9_den_q[30] ? (32'd0 - den32) : den32;
      s10_side_q.centi <= s9_centi_q;
      s10_side_q.zero  <= s9_zero_q;
      s10_side_q.neg   <= s9_num_q[63] ^ s9_den_q[30];
    end
  end

  logic                 dv_valid;
  logic [63:0]          dv_quot;
  prtc_pkg::div_side_t  dv_side;

  prtc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (sv_q[10]),
    .dividend_i  (s10_ma_q),
    .divisor_i   (s10_mb_q),
    .side_i      (s10_side_q),
    .out_valid_o (dv_valid),
    .quotient_o  (dv_quot),
    .side_o      (dv_side)
  );

  // post-division correction terms
  logic [63:0]        p0_p_q;
  logic signed [26:0] p0_centi_q, p1_centi_q, p2_centi_q, p3_centi_q;
  logic               p0_zero_q, p1_zero_q, p2_zero_q, p3_zero_q;
  logic [63:0]        s_w;
  logic [31:0]        hl;
  logic signed [79:0] p8p_full, x_full;
  logic [63:0]        p1_ll_q, p1_p8p_q, p1_p_q;
  logic [31:0]        p1_hl_q;
  logic [63:0]        p2_ss_q;
  logic [39:0]        p2_c2_q, p2_p40_q, p3_c2_q, p3_p40_q;
  logic [63:0]        p3_x_q;
  logic [39:0]        c1, sum40;
  logic [27:0]        p7_x;
  prtc_pkg::out_t     p4_res_d, p4_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[3:0], dv_valid};
    end
  end

  assign s_w      = 64'($signed(p0_p_q) >>> 13);
  assign hl       = s_w[63:32] * s_w[31:0];
  assign p8p_full = $signed(p0_p_q) * p8_s;
  assign x_full   = $signed(p2_ss_q) * p9_s;

  assign c1    = {p3_x_q[63], p3_x_q[63:25]};
  assign sum40 = p3_p40_q + c1 + p3_c2_q;
  assign p7_x  = 28'(p7_s);

  always_comb begin
    p4_res_d.temperature_centi = p3_centi_q;
    p4_res_d.divisor_zero      = p3_zero_q;
    p4_res_d.pressure_q24_8    = p3_zero_q ? 32'd0 : (sum40[39:8] + {p7_x, 4'd0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_p_q     <= dv_side.neg ? (64'd0 - dv_quot) : dv_quot;
      p0_centi_q <= dv_side.centi;
      p0_zero_q  <= dv_side.zero;

      p1_ll_q    <= {32'd0, s_w[31:0]} * {32'd0, s_w[31:0]};
      p1_hl_q    <= hl;
      p1_p8p_q   <= p8p_full[63:0];
      p1_p_q     <= p0_p_q;
      p1_centi_q <= p0_centi_q;
      p1_zero_q  <= p0_zero_q;

      // low 64 bits of s*s from the split halves
      p2_ss_q    <= p1_ll_q + {p1_hl_q[30:0], 33'd0};
      p2_c2_q    <= p1_p8p_q[58:19];
      p2_p40_q   <= p1_p_q[39:0];
      p2_centi_q <= p1_centi_q;
      p2_zero_q  <= p1_zero_q;

      p3_x_q     <= x_full[63:0];
      p3_c2_q    <= p2_c2_q;
      p3_p40_q   <= p2_p40_q;
      p3_centi_q <= p2_centi_q;
      p3_zero_q  <= p2_zero_q;

      p4_res_q   <= p4_res_d;
    end
  end

  // two-entry output buffer
  logic           out_valid_q;
  prtc_pkg::out_t out_data_q, skid_data_q;
  logic           push, pop;

  assign push = en & pv_q[4];
  assign pop  = out_valid_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_data_q <= p4_res_q;
      end else begin
        out_data_q <= p4_res_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("buffer entry held without an output transaction");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !pop) |=> (skid_valid_q && $stable(skid_data_q)))
    else $error("buffered transaction lost");

  a_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.divisor_zero) |-> (out_data_q.pressure_q24_8 == 32'd0))
    else $error("zero divisor with nonzero pressure");
`endif

endmodule

>>> rtl/prtc_div.sv
`timescale 1ns / 1ps
module prtc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [prtc_pkg::DivW-1:0]     dividend_i,
  input  logic [prtc_pkg::RemW-1:0]     divisor_i,
  input  prtc_pkg::div_side_t           side_i,
  output logic                          out_valid_o,
  output logic [prtc_pkg::DivW-1:0]     quotient_o,
  output prtc_pkg::div_side_t           side_o
);

  localparam int unsigned NStages = prtc_pkg::DivW;

  logic [NStages-1:0]          v_q;
  logic [prtc_pkg::RemW-1:0]   rem_q  [NStages];
  logic [prtc_pkg::DivW-1:0]   nq_q   [NStages];
  logic [prtc_pkg::RemW-1:0]   dv_q   [NStages];
  prtc_pkg::div_side_t         side_q [NStages];

  for (genvar k = 0; k < NStages; k++) begin : g_stage
    logic                        v_in;
    logic [prtc_pkg::RemW-1:0]   rem_in;
    logic [prtc_pkg::DivW-1:0]   nq_in;
    logic [prtc_pkg::RemW-1:0]   dv_in;
    prtc_pkg::div_side_t         side_in;
    logic [prtc_pkg::RemW-1:0]   trial;
    logic                        ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = '0;
      assign nq_in   = dividend_i;
      assign dv_in   = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign dv_in   = dv_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in[prtc_pkg::RemW-2:0], nq_in[prtc_pkg::DivW-1]};
    assign ge    = (trial >= dv_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (trial - dv_in) : trial;
        nq_q[k]   <= {nq_in[prtc_pkg::DivW-2:0], ge};
        dv_q[k]   <= dv_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid_o = v_q[NStages-1];
  assign quotient_o  = nq_q[NStages-1];
  assign side_o      = side_q[NStages-1];

endmodule

>>> dv/pressure_temperature_compensation_top_tb.sv
`timescale 1ns / 1ps
module pressure_temperature_compensation_top_tb;

  // Bit-exact model of the trim compensation; holds its own trim registers.
  class compensation_scoreboard;
    logic [47:0] temp_trim;
    logic [63:0] press_a, press_b;
    logic [15:0] press_c;
    prtc_pkg::out_t pending_results[$];
    int          mismatches;

    function new();
      temp_trim = '0;
      press_a = '0;
      press_b = '0;
      press_c = '0;
      mismatches = 0;
    endfunction

    function void write_trim(prtc_pkg::cfg_idx_e idx, logic [63:0] val);
      case (idx)
        prtc_pkg::CfgTempTrim: temp_trim = val[47:0];
        prtc_pkg::CfgPressA:   press_a = val;
        prtc_pkg::CfgPressB:   press_b = val;
        prtc_pkg::CfgPressC:   press_c = val[15:0];
        default: ;
      endcase
    endfunction

    function prtc_pkg::out_t compensate(prtc_pkg::in_t din);
      logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] adc_t, adc_p, d1, v1, d2, v2, fine, centi;
      logic signed [63:0] a, b, p, s, c1, c2, na, nb, q;
      prtc_pkg::out_t r;
      adc_t = {44'd0, din.raw_temperature};
      adc_p = {44'd0, din.raw_pressure};
      t1 = {48'd0, temp_trim[15:0]};
      t2 = {{48{temp_trim[31]}}, temp_trim[31:16]};
      t3 = {{48{temp_trim[47]}}, temp_trim[47:32]};
      p1 = {48'd0, press_a[15:0]};
      p2 = {{48{press_a[31]}}, press_a[31:16]};
      p3 = {{48{press_a[47]}}, press_a[47:32]};
      p4 = {{48{press_a[63]}}, press_a[63:48]};
      p5 = {{48{press_b[15]}}, press_b[15:0]};
      p6 = {{48{press_b[31]}}, press_b[31:16]};
      p7 = {{48{press_b[47]}}, press_b[47:32]};
      p8 = {{48{press_b[63]}}, press_b[63:48]};
      p9 = {{48{press_c[15]}}, press_c};
      d1 = (adc_t >>> 3) - (t1 <<< 1);
      v1 = (d1 * t2) >>> 11;
      d2 = (adc_t >>> 4) - t1;
      v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
      fine = v1 + v2;
      centi = (fine * 5 + 128) >>> 8;
      a = fine - 64'sd128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
      r.temperature_centi = centi[26:0];
      if (a == 0) begin
        r.pressure_q24_8 = '0;
        r.divisor_zero = 1'b1;
      end else begin
        p = 64'sd1048576 - adc_p;
        na = ((p <<< 31) - b) * 3125;
        nb = a;
        // truncating division on magnitudes; wraps for -2^63 / -1
        q = $signed($unsigned(na[63] ? -na : na) / $unsigned(nb[63] ? -nb : nb));
        p = (na[63] != nb[63]) ? -q : q;
        s = p >>> 13;
        c1 = (p9 * s * s) >>> 25;
        c2 = (p8 * p) >>> 19;
        p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
        r.pressure_q24_8 = p[31:0];
        r.divisor_zero = 1'b0;
      end
      return r;
    endfunction

    function void note_input(prtc_pkg::in_t din);
      pending_results.push_back(compensate(din));
    endfunction

    function void check_result(prtc_pkg::out_t got);
      prtc_pkg::out_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp centi=%0d press=%h zero=%b got centi=%0d press=%h zero=%b",
                   exp_r.temperature_centi, exp_r.pressure_q24_8, exp_r.divisor_zero,
                   got.temperature_centi, got.pressure_q24_8, got.divisor_zero);
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  prtc_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  prtc_pkg::out_t out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [1:0]     cfg_idx_i = '0;
  logic [63:0]    cfg_data_i = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  compensation_scoreboard sb = new();

  pressure_temperature_compensation_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_trim(prtc_pkg::cfg_idx_e idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_trim(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_reading(logic [19:0] rt, logic [19:0] rp);
    prtc_pkg::in_t d;
    d.raw_temperature = rt;
    d.raw_pressure = rp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Typical datasheet-like trim set, randomized around nominal values.
  task automatic load_typical_trim();
    write_trim(prtc_pkg::CfgTempTrim, {16'($urandom_range(40, 0) - 20 + 50), 16'(26000 +
               $urandom_range(2000)), 16'(27000 + $urandom_range(2000))});
    write_trim(prtc_pkg::CfgPressA, {16'(2500 + $urandom_range(1000)),
               16'($urandom_range(3000) + 3000),
               16'(-10500 - $urandom_range(500)), 16'(35000 + $urandom_range(3000))});
    write_trim(prtc_pkg::CfgPressB, {16'(-16'sd7 - $urandom_range(10)),
               16'(15000 + $urandom_range(500)),
               16'(-16'sd7), 16'(140 - $urandom_range(10))});
    write_trim(prtc_pkg::CfgPressC, 64'(6000 + $urandom_range(200)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random_trim();
    write_trim(prtc_pkg::CfgTempTrim, {$urandom, $urandom});
    write_trim(prtc_pkg::CfgPressA, {$urandom, $urandom});
    write_trim(prtc_pkg::CfgPressB, {$urandom, $urandom});
    write_trim(prtc_pkg::CfgPressC, 64'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_readings(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_reading(20'($urandom), 20'($urandom));
      else send_reading(20'(500000 + $urandom_range(100000)),
                        20'(400000 + $urandom_range(100000)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset trims: divisor is zero
    send_reading('0, '0);
    send_reading('1, '1);
    drain();
    load_typical_trim();
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'd519888, 20'd415148);
    send_reading('1, '0);
    send_reading('0, '1);
    send_reading(20'h80000, 20'h80000);
    drain();
    // extreme trims
    write_trim(prtc_pkg::CfgTempTrim, '1);
    write_trim(prtc_pkg::CfgPressA, '1);
    write_trim(prtc_pkg::CfgPressB, '1);
    write_trim(prtc_pkg::CfgPressC, '1);
    cfg_we_i <= 1'b0;
    send_reading('0, '0);
    send_reading('1, '1);
    drain();
    write_trim(prtc_pkg::CfgTempTrim, {16'h7fff, 16'h7fff, 16'hffff});
    write_trim(prtc_pkg::CfgPressA, {16'h8000, 16'h8000, 16'h8000, 16'h0001});
    write_trim(prtc_pkg::CfgPressB, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    write_trim(prtc_pkg::CfgPressC, 64'h8000);
    cfg_we_i <= 1'b0;
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'h55555, 20'haaaaa);
    drain();

    send_idle_pct = 16;
    recv_idle_pct = 87;
    load_typical_trim();
    random_readings(250);
    drain();
    load_random_trim();
    random_readings(100);
    drain();

    send_idle_pct = 87;
    recv_idle_pct = 16;
    load_typical_trim();
    random_readings(250);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random_trim();
    random_readings(100);
    drain();
    load_typical_trim();
    random_readings(300);
    drain();

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
